[rtl/core/atm_pkg.sv]
package atm_pkg;

	// Field widths
	localparam int ACCEL_W = 16;
	localparam int PITCH_W = 15;
	localparam int ROLL_W  = 16;
	localparam int MAG_W   = 16;

	// Angle formats: accumulator in degrees * 2^ACC_FRAC, output in degrees * 2^ANGLE_FRAC_BITS
	localparam int ACC_FRAC        = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ACC_W           = 26;
	localparam int TABLE_LEN       = 24;
	localparam int ITER_STAGES_DEF = 16;

	// Rotator operands carry counts * 2^OP_FRAC
	localparam int OP_FRAC = 14;
	localparam int CW      = 33;

	// Root of (x^2 + z^2) * 2^(2*OP_FRAC)
	localparam int DEN_W = 30;

	localparam int PITCH_LIM_DEG = 90;
	localparam int ROLL_LIM_DEG  = 180;

	localparam logic [MAG_W-1:0] THRESH_RST = 16'd16384;

	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic signed [PITCH_W-1:0] pitch_t;
	typedef logic signed [ROLL_W-1:0]  roll_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic signed [CW-1:0]      cw_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	localparam acc_t DEG180_ACC = 26'sd11796480;

	typedef struct packed {
		pitch_t pitch_angle;
		roll_t  roll_angle;
		mag_t   accel_magnitude;
		logic   shake;
	} res_t;

	// round(atan(2^-i) * 180/pi * 2^16)
	function automatic acc_t atan_q16(input int unsigned idx);
		acc_t r;
		unique case (idx)
			0:       r = acc_t'(2949120);
			1:       r = acc_t'(1740967);
			2:       r = acc_t'(919879);
			3:       r = acc_t'(466945);
			4:       r = acc_t'(234379);
			5:       r = acc_t'(117304);
			6:       r = acc_t'(58666);
			7:       r = acc_t'(29335);
			8:       r = acc_t'(14668);
			9:       r = acc_t'(7334);
			10:      r = acc_t'(3667);
			11:      r = acc_t'(1833);
			12:      r = acc_t'(917);
			13:      r = acc_t'(458);
			14:      r = acc_t'(229);
			15:      r = acc_t'(115);
			16:      r = acc_t'(57);
			17:      r = acc_t'(29);
			18:      r = acc_t'(14);
			19:      r = acc_t'(7);
			20:      r = acc_t'(4);
			21:      r = acc_t'(2);
			22:      r = acc_t'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/atm_if.sv]
interface atm_sample_if;
	logic            valid;
	logic            ready;
	atm_pkg::accel_t accel_x;
	atm_pkg::accel_t accel_y;
	atm_pkg::accel_t accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atm_result_if;
	logic            valid;
	logic            ready;
	atm_pkg::pitch_t pitch_angle;
	atm_pkg::roll_t  roll_angle;
	atm_pkg::mag_t   accel_magnitude;
	logic            shake;

	modport source (output valid, output pitch_angle, output roll_angle,
		output accel_magnitude, output shake, input ready);
	modport sink   (input valid, input pitch_angle, input roll_angle,
		input accel_magnitude, input shake, output ready);
endinterface

[rtl/core/accel_tilt_and_magnitude.sv]
// Tilt and magnitude from raw three-axis accelerometer samples.
// sample (sink): one item is one signed 16-bit x/y/z triple in raw counts.
// result (source): pitch and roll in 1/128 degree, rounded magnitude in counts,
//   and shake, set when the magnitude is above the shake threshold register.
// cfg_we/cfg_wdata write the shake threshold; change it only while idle.
// Throughput: one item per cycle unless both output buffer entries are full.
//   Path to result.valid: the input registers, one sum stage after them, the
//   30-stage root of x^2+z^2 that feeds the pitch rotator, one operand stage,
//   the rotator stages, one rounding stage and the write into the output buffer.
// All stages advance together on one enable; a two-entry output buffer ends
//   the pipeline, so input is still taken while one result waits unclaimed.
//   The pipeline holds only while both buffer entries are full.
// Reset empties the pipeline and the buffer and sets the threshold to 16384.
module accel_tilt_and_magnitude import atm_pkg::*; #(
	parameter int ITER_STAGES = ITER_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	atm_sample_if.sink         sample,
	atm_result_if.source       result,
	input  logic               cfg_we,
	input  logic [MAG_W-1:0]   cfg_wdata
);

	localparam int N_IT    = (ITER_STAGES < TABLE_LEN) ? ITER_STAGES : TABLE_LEN;
	localparam int VLAT    = 2 + DEN_W + N_IT + 2;
	localparam int MAG_DLY = DEN_W - MAG_W + N_IT + 2;
	localparam int PAD_W   = 2 * DEN_W - 32;
	localparam int PITCH_LIM = PITCH_LIM_DEG << ANGLE_FRAC_BITS;
	localparam int ROLL_LIM  = ROLL_LIM_DEG << ANGLE_FRAC_BITS;

	logic              en;
	logic              accept;
	logic              push;
	logic              pop;
	logic [VLAT-1:0]   vld_q;
	logic [MAG_W-1:0]  thr_q;

	logic signed [31:0] px, py, pz;
	accel_t       x_s1, y_s1, z_s1;
	logic [30:0]  sqx_s1, sqy_s1, sqz_s1;
	accel_t       x_s2, y_s2, z_s2;
	logic [31:0]  sxz_s2, sall_s2;

	accel_t       x_d [DEN_W];
	accel_t       y_d [DEN_W];
	accel_t       z_d [DEN_W];
	mag_t         mag_d [MAG_DLY];

	logic [DEN_W-1:0] den_root;
	mag_t             mag_root;
	logic [MAG_W:0]   mag_rem;
	mag_t             mag_r;

	cw_t  p_y, p_x, r_y, r_x;
	acc_t pitch_ang, roll_ang;

	res_t        res_c;
	res_t        ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	// Stall the whole pipeline only when both buffer entries are taken
	assign en     = (cnt_q != 2'd2);
	assign accept = sample.valid && en;
	assign push   = vld_q[VLAT-1] && en;
	assign pop    = result.valid && result.ready;
	assign sample.ready = en;

	assign px = 32'(sample.accel_x) * 32'(sample.accel_x);
	assign py = 32'(sample.accel_y) * 32'(sample.accel_y);
	assign pz = 32'(sample.accel_z) * 32'(sample.accel_z);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= sample.accel_x;
			y_s1   <= sample.accel_y;
			z_s1   <= sample.accel_z;
			sqx_s1 <= px[30:0];
			sqy_s1 <= py[30:0];
			sqz_s1 <= pz[30:0];

			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			sxz_s2  <= 32'(sqx_s1) + 32'(sqz_s1);
			sall_s2 <= 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);

			// Hold the raw axes until the pitch denominator is done
			x_d[0] <= x_s2;
			y_d[0] <= y_s2;
			z_d[0] <= z_s2;
			for (int k = 1; k < DEN_W; k++) begin
				x_d[k] <= x_d[k-1];
				y_d[k] <= y_d[k-1];
				z_d[k] <= z_d[k-1];
			end

			mag_d[0] <= mag_r;
			for (int k = 1; k < MAG_DLY; k++) begin
				mag_d[k] <= mag_d[k-1];
			end
		end
	end

	atm_sqrt #(
		.ROOT_W (DEN_W)
	) u_den_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({sxz_s2, {PAD_W{1'b0}}}),
		.root (den_root),
		.rem  ()
	);

	atm_sqrt #(
		.ROOT_W (MAG_W)
	) u_mag_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sall_s2),
		.root (mag_root),
		.rem  (mag_rem)
	);

	// Round to nearest: bump when the remainder passes the root
	assign mag_r = mag_root + mag_t'(mag_rem > {1'b0, mag_root});

	assign p_y = cw_t'(y_d[DEN_W-1]) <<< OP_FRAC;
	assign p_x = cw_t'(den_root);
	assign r_y = -(cw_t'(x_d[DEN_W-1]) <<< OP_FRAC);
	assign r_x = cw_t'(z_d[DEN_W-1]) <<< OP_FRAC;

	atm_cordic #(
		.ITER_STAGES (ITER_STAGES),
		.LIMIT_DEG   (PITCH_LIM_DEG)
	) u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (p_y),
		.x_in  (p_x),
		.angle (pitch_ang)
	);

	atm_cordic #(
		.ITER_STAGES (ITER_STAGES),
		.LIMIT_DEG   (ROLL_LIM_DEG)
	) u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (r_y),
		.x_in  (r_x),
		.angle (roll_ang)
	);

	always_comb begin
		res_c.pitch_angle     = pitch_t'(pitch_ang);
		res_c.roll_angle      = roll_t'(roll_ang);
		res_c.accel_magnitude = mag_d[MAG_DLY-1];
		res_c.shake           = (mag_d[MAG_DLY-1] > thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			thr_q    <= THRESH_RST;
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[VLAT-2:0], accept};
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= res_c;
		end
	end

	assign result.valid           = (cnt_q != 2'd0);
	assign result.pitch_angle     = ent_q[rd_ptr_q].pitch_angle;
	assign result.roll_angle      = ent_q[rd_ptr_q].roll_angle;
	assign result.accel_magnitude = ent_q[rd_ptr_q].accel_magnitude;
	assign result.shake           = ent_q[rd_ptr_q].shake;

	a_full_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !result.ready) |=> $stable(vld_q))
		else $error("pipeline moved while the output buffer was full");

	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("buffer count missed a push");

	a_cnt_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("buffer count missed a pop");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pitch_angle <= PITCH_LIM && result.pitch_angle >= -PITCH_LIM))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.roll_angle <= ROLL_LIM && result.roll_angle >= -ROLL_LIM))
		else $error("roll out of range");

endmodule

[rtl/core/atm_sqrt.sv]
module atm_sqrt #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2*ROOT_W-1:0]   rad,
	output logic [ROOT_W-1:0]     root,
	output logic [ROOT_W:0]       rem
);

	typedef struct packed {
		logic [2*ROOT_W-1:0] rad;
		logic [ROOT_W-1:0]   root;
		logic [ROOT_W:0]     rem;
	} sq_st_t;

	sq_st_t init;
	sq_st_t st_s [ROOT_W];

	// One root bit per stage, restoring recurrence; rem ends as rad - root^2
	function automatic sq_st_t sq_step(sq_st_t s);
		logic [ROOT_W+2:0] cat;
		logic [ROOT_W+2:0] trial;
		logic [ROOT_W+2:0] diff;
		sq_st_t n;
		cat   = {s.rem, s.rad[2*ROOT_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		diff  = cat - trial;
		n.rad = {s.rad[2*ROOT_W-3:0], 2'b00};
		if (cat >= trial) begin
			n.rem  = diff[ROOT_W:0];
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = cat[ROOT_W:0];
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	always_comb begin
		init.rad  = rad;
		init.root = '0;
		init.rem  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= sq_step(init);
			for (int k = 1; k < ROOT_W; k++) begin
				st_s[k] <= sq_step(st_s[k-1]);
			end
		end
	end

	assign root = st_s[ROOT_W-1].root;
	assign rem  = st_s[ROOT_W-1].rem;

endmodule

[rtl/core/atm_cordic.sv]
module atm_cordic import atm_pkg::*; #(
	parameter int ITER_STAGES = ITER_STAGES_DEF,
	parameter int LIMIT_DEG   = PITCH_LIM_DEG
) (
	input  logic clk,
	input  logic en,
	input  cw_t  y_in,
	input  cw_t  x_in,
	output acc_t angle
);

	localparam int   N_IT = (ITER_STAGES < TABLE_LEN) ? ITER_STAGES : TABLE_LEN;
	localparam int   SH   = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam acc_t HALF = acc_t'(1 << (SH - 1));
	localparam acc_t LIM  = acc_t'(LIMIT_DEG << ANGLE_FRAC_BITS);
	localparam acc_t NLIM = -LIM;

	typedef struct packed {
		cw_t  x;
		cw_t  y;
		acc_t z;
		logic zero;
	} cst_t;

	cst_t pre;
	cst_t cst_s [N_IT+1];
	acc_t sum;
	acc_t rnd;
	acc_t ang;
	acc_t angle_s;

	function automatic cst_t cr_step(cst_t s, int unsigned i);
		cst_t n;
		n = s;
		if (!s.y[CW-1] && (s.y != '0)) begin
			n.x = s.x + (s.y >>> i);
			n.y = s.y - (s.x >>> i);
			n.z = s.z + atan_q16(i);
		end else begin
			n.x = s.x - (s.y >>> i);
			n.y = s.y + (s.x >>> i);
			n.z = s.z - atan_q16(i);
		end
		return n;
	endfunction

	// Fold a negative x operand into the right half plane, starting at +-180 degrees
	always_comb begin
		pre.zero = (x_in == '0) && (y_in == '0);
		if (x_in[CW-1]) begin
			pre.x = -x_in;
			pre.y = -y_in;
			pre.z = y_in[CW-1] ? -DEG180_ACC : DEG180_ACC;
		end else begin
			pre.x = x_in;
			pre.y = y_in;
			pre.z = '0;
		end
	end

	always_comb begin
		sum = cst_s[N_IT].z + HALF;
		rnd = sum >>> SH;
		priority if (cst_s[N_IT].zero) begin
			ang = '0;
		end else if (rnd > LIM) begin
			ang = LIM;
		end else if (rnd < NLIM) begin
			ang = NLIM;
		end else begin
			ang = rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cst_s[0] <= pre;
			for (int i = 0; i < N_IT; i++) begin
				cst_s[i+1] <= cr_step(cst_s[i], i);
			end
			angle_s <= ang;
		end
	end

	assign angle = angle_s;

endmodule

[dv/tb.sv]
module tb;
	import atm_pkg::*;

	localparam int ROT_STAGES  = ITER_STAGES_DEF;
	localparam int LATENCY     = ROT_STAGES + 34;
	localparam int END_WAIT    = LATENCY + 20;
	localparam int STALL_LIMIT = 2000;
	localparam int ATAN_LEN    = 24;
	localparam int ROUND_SH    = 16 - ANGLE_FRAC_BITS;
	localparam longint DEG180_Q16 = 64'sd11796480;
	localparam longint OP_SCALE   = 64'sd16384;

	// atan(2^-i) in degrees * 2^16
	localparam longint ATAN_DEG_Q16 [ATAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef enum int {AX_FULL, AX_GRAVITY, AX_TINY, AX_EDGE} axis_mode_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [MAG_W-1:0] cfg_wdata;

	atm_sample_if smp();
	atm_result_if res();

	accel_tilt_and_magnitude uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	res_t tilt_expected_q[$];
	mag_t shake_limit = THRESH_RST;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   err_count = 0;
	int   stall_cycles = 0;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, rem, step_v;
		root = 0;
		rem = n;
		step_v = 64'd1 << 62;
		while (step_v > rem)
			step_v >>= 2;
		while (step_v != 0) begin
			if (rem >= root + step_v) begin
				rem -= root + step_v;
				root = (root >> 1) + step_v;
			end else begin
				root >>= 1;
			end
			step_v >>= 2;
		end
		return root;
	endfunction

	// Vectoring rotation: drive yv to zero, accumulate the angle in degrees * 2^16
	function automatic longint vector_angle(input longint yv, input longint xv);
		longint ang, nx, ny;
		int i;
		ang = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			ang = (yv >= 0) ? DEG180_Q16 : -DEG180_Q16;
			xv = -xv;
			yv = -yv;
		end
		for (i = 0; i < ROT_STAGES && i < ATAN_LEN; i++) begin
			if (yv > 0) begin
				nx = xv + (yv >>> i);
				ny = yv - (xv >>> i);
				ang += ATAN_DEG_Q16[i];
			end else begin
				nx = xv - (yv >>> i);
				ny = yv + (xv >>> i);
				ang -= ATAN_DEG_Q16[i];
			end
			xv = nx;
			yv = ny;
		end
		return ang;
	endfunction

	function automatic longint round_angle(input longint acc, input longint lim_deg);
		longint r, lim;
		lim = lim_deg << ANGLE_FRAC_BITS;
		r = (acc + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic res_t predict_tilt(input accel_t ax, input accel_t ay, input accel_t az);
		longint xs, ys, zs, den, p, r;
		longint unsigned sxz, sall, m;
		res_t e;
		xs = ax;
		ys = ay;
		zs = az;
		sxz = xs * xs + zs * zs;
		sall = sxz + ys * ys;
		m = int_sqrt(sall);
		if (sall - m * m > m)
			m++;
		den = int_sqrt(sxz << 28);
		p = round_angle(vector_angle(ys * OP_SCALE, den), PITCH_LIM_DEG);
		r = round_angle(vector_angle(-xs * OP_SCALE, zs * OP_SCALE), ROLL_LIM_DEG);
		e.pitch_angle = p[PITCH_W-1:0];
		e.roll_angle = r[ROLL_W-1:0];
		e.accel_magnitude = m[MAG_W-1:0];
		e.shake = (m > shake_limit);
		return e;
	endfunction

	function automatic accel_t rand_axis(input axis_mode_e mode);
		accel_t v;
		case (mode)
			AX_FULL:    v = accel_t'($urandom);
			AX_GRAVITY: v = accel_t'(int'($urandom_range(20000)) - 10000);
			AX_TINY:    v = accel_t'(int'($urandom_range(8)) - 4);
			default: begin
				case ($urandom_range(4))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sh0001;
					3: v = 16'shFFFF;
					default: v = '0;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_sample(input accel_t ax, input accel_t ay, input accel_t az);
		while ($urandom_range(99) < send_idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.accel_x <= ax;
		smp.accel_y <= ay;
		smp.accel_z <= az;
		do @(posedge clk); while (!smp.ready);
		tilt_expected_q.push_back(predict_tilt(ax, ay, az));
	endtask

	// Drop valid and hold until every outstanding item has produced its result
	task automatic wait_drained();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (tilt_expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_shake_threshold(input mag_t value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shake_limit = value;
	endtask

	task automatic test_directed_extremes();
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sd0, 16'sd0, 16'sd8192);
		send_sample(16'sd0, 16'sd0, -16'sd8192);
		send_sample(16'sd0, 16'sd0, -16'sd1);
		send_sample(16'sd8192, 16'sd0, 16'sd0);
		send_sample(-16'sd8192, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd8192, 16'sd0);
		send_sample(16'sd0, -16'sd8192, 16'sd0);
		send_sample(16'sd0, 16'sh7FFF, 16'sd0);
		send_sample(16'sd0, 16'sh8000, 16'sd0);
		send_sample(16'sd0, 16'sd1, 16'sd0);
		send_sample(16'sd1, 16'sd1, 16'sd1);
		send_sample(-16'sd1, -16'sd1, -16'sd1);
		// magnitude equal to the reset threshold, then one above it
		send_sample(16'sd16384, 16'sd0, 16'sd0);
		send_sample(16'sd16385, 16'sd0, 16'sd0);
		send_sample(16'sh8000, 16'sd0, 16'sh8000);
		send_sample(16'sh7FFF, 16'sd0, 16'sh8000);
		send_sample(16'sd0, 16'sd0, 16'sh7FFF);
		send_sample(16'sd0, 16'sd0, 16'sh8000);
		send_sample(16'sd5793, 16'sd5793, 16'sd0);
		send_sample(16'sd5000, -16'sd3000, 16'sd7000);
	endtask

	task automatic test_shake_threshold_edges();
		set_shake_threshold(16'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd1);
		set_shake_threshold(16'hFFFF);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh7FFF, -16'sd12000, 16'sh8000);
	endtask

	task automatic test_random_traffic(input int count);
		int pick;
		accel_t ax, ay, az;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				ax = rand_axis(AX_FULL);
				ay = rand_axis(AX_FULL);
				az = rand_axis(AX_FULL);
			end else if (pick < 70) begin
				ax = rand_axis(AX_GRAVITY);
				ay = rand_axis(AX_GRAVITY);
				az = rand_axis(AX_GRAVITY);
			end else if (pick < 85 || shake_limit > 16'd32766) begin
				ax = rand_axis(axis_mode_e'($urandom_range(3)));
				ay = rand_axis(axis_mode_e'($urandom_range(3)));
				az = rand_axis(axis_mode_e'($urandom_range(3)));
			end else begin
				// magnitude straddling the threshold on one axis
				ax = accel_t'(int'(shake_limit) + int'($urandom_range(2)) - 1);
				if ($urandom_range(1))
					ax = -ax;
				ay = '0;
				az = '0;
			end
			send_sample(ax, ay, az);
		end
	endtask

	task automatic test_drain_pause();
		test_random_traffic(30);
		wait_drained();
		test_random_traffic(30);
	endtask

	always @(posedge clk) begin : result_check
		res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got.pitch_angle = res.pitch_angle;
			got.roll_angle = res.roll_angle;
			got.accel_magnitude = res.accel_magnitude;
			got.shake = res.shake;
			if (tilt_expected_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: pitch %0d roll %0d mag %0d shake %0d",
						$signed(got.pitch_angle), $signed(got.roll_angle),
						got.accel_magnitude, got.shake);
			end else begin
				want = tilt_expected_q.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch: pitch %0d/%0d roll %0d/%0d mag %0d/%0d ",
							"shake %0d/%0d (expected/actual)"},
							$signed(want.pitch_angle), $signed(got.pitch_angle),
							$signed(want.roll_angle), $signed(got.roll_angle),
							want.accel_magnitude, got.accel_magnitude,
							want.shake, got.shake);
				end
			end
		end
		res.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		smp.valid <= 1'b0;
		smp.accel_x <= '0;
		smp.accel_y <= '0;
		smp.accel_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 63;
		test_directed_extremes();
		test_shake_threshold_edges();

		set_shake_threshold(16'($urandom_range(4096, 24576)));
		test_random_traffic(120);
		test_drain_pause();
		test_random_traffic(120);

		set_shake_threshold(16'($urandom_range(8000, 40000)));
		send_idle_pct = 63;
		recv_idle_pct = 18;
		test_random_traffic(270);

		set_shake_threshold(16'd8192);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(250);

		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[accel_tilt_and_magnitude.f]
rtl/core/atm_pkg.sv
rtl/core/atm_if.sv
rtl/core/atm_sqrt.sv
rtl/core/atm_cordic.sv
rtl/core/accel_tilt_and_magnitude.sv
dv/tb.sv
